>>> hdl/sprp_pkg.sv
`default_nettype none
package sprp_pkg;

   localparam int STAGES     = 10;
   localparam int LAST_STAGE = 2 * STAGES;
   localparam int STAGE_W    = 5;
   localparam int FACTOR_W   = 17;
   localparam int PERIOD_W   = 16;
   localparam int CSR_IDX_W  = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_PERIOD = 2'd0,
      CSR_DUTY        = 2'd1,
      CSR_TUNE_ENABLE = 2'd2
   } csr_index_type;

   typedef enum logic {
      KIND_MOVE  = 1'b0,
      KIND_PULSE = 1'b1
   } kind_type;

   localparam logic [PERIOD_W-1:0] BASE_PERIOD_RST = 16'd1000;
   localparam logic [PERIOD_W-1:0] DUTY_RST        = 16'd500;

   // x / 5 == (x * RECIP_5) >> 34 for any 32-bit x
   localparam logic [31:0] RECIP_5     = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 34;

   // Q1.16 sigmoid factor for the first half of the profile
   function automatic logic [FACTOR_W-1:0] stage_factor(input logic [STAGE_W-1:0] k);
      logic [FACTOR_W-1:0] f;
      case (k)
         5'd0:    f = 17'd65536;
         5'd1:    f = 17'd64357;
         5'd2:    f = 17'd62428;
         5'd3:    f = 17'd57724;
         5'd4:    f = 17'd47911;
         5'd5:    f = 17'd32768;
         5'd6:    f = 17'd17625;
         5'd7:    f = 17'd7812;
         5'd8:    f = 17'd3108;
         5'd9:    f = 17'd1179;
         default: f = 17'd0;
      endcase
      return f;
   endfunction

endpackage
`default_nettype wire

>>> hdl/stepper_pulse_ramp_profile_top.sv
// Stepper pulse counter with an S-curve PWM period ramp.
//
// req channel: one word per command. kind = move carries a pulse count
// (zero means stop); kind = pulse reports one finished PWM pulse.
// rsp channel: exactly one word per req word, in order, carrying the PWM
// enable/disable/period commands, done and start flags and the pulses left.
// csr port: base_period, duty and tune_enable, written with csr_write_enable;
// write only while no word is in flight.
//
// A req word passes an input register, then the state update and period
// math into the rsp register, where rsp_valid rises. Throughput is one
// word per cycle while rsp_ready does not stall the pipe; the per-word
// path holds one 16x17 period multiply and one 32x32 reciprocal multiply
// for count/80, in parallel. The stage threshold offset is kept as a
// running sum, so no multiply is needed on the threshold compare.
//
// Reset (synchronous) idles the block, clears the pipe and loads register
// defaults. When rsp_ready is low the rsp word holds, the input register
// fills, and then req_ready drops.
`default_nettype none
module stepper_pulse_ramp_profile_top
   import sprp_pkg::*;
#(
   parameter int STEP_BITS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_kind,
   input  wire logic [31:0]           req_step_count,

   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_pwm_enable,
   output logic                       rsp_pwm_disable,
   output logic                       rsp_period_write,
   output logic [PERIOD_W-1:0]        rsp_period_value,
   output logic [PERIOD_W-1:0]        rsp_duty_value,
   output logic                       rsp_move_done,
   output logic                       rsp_start_accepted,
   output logic [31:0]                rsp_steps_left,

   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [PERIOD_W-1:0]   csr_write_data
);

   localparam int UNIT_BITS = STEP_BITS - 6;

   // registers
   logic [PERIOD_W-1:0]  base_period_ff;
   logic [PERIOD_W-1:0]  duty_ff;
   logic                 tune_enable_ff;

   logic                 s1_valid_ff;
   logic                 s1_kind_ff;
   logic [STEP_BITS-1:0] s1_count_ff;

   logic                 running_ff, running_in;
   logic [STEP_BITS-1:0] remaining_ff, remaining_in;
   logic [STEP_BITS-1:0] total_ff, total_in;
   logic [UNIT_BITS-1:0] unit_ff, unit_in;
   logic [STAGE_W-1:0]   stage_ff, stage_in;
   logic [STEP_BITS-1:0] offset_ff, offset_in;

   logic                 rsp_valid_ff;
   logic                 pwm_enable_ff, pwm_enable_in;
   logic                 pwm_disable_ff, pwm_disable_in;
   logic                 period_write_ff, period_write_in;
   logic [PERIOD_W-1:0]  period_value_ff, period_value_in;
   logic [PERIOD_W-1:0]  duty_value_ff, duty_value_in;
   logic                 move_done_ff, move_done_in;
   logic                 start_accepted_ff, start_accepted_in;

   // datapath
   logic                 advance;
   logic [31:0]          div_x;
   logic [63:0]          div_prod;
   logic [UNIT_BITS-1:0] quotient;
   logic [STEP_BITS-1:0] rem_dec;
   logic [STEP_BITS-1:0] threshold;
   logic [STAGE_W-1:0]   next_stage;
   logic [STAGE_W-1:0]   factor_idx;
   logic [32:0]          period_prod;
   logic [PERIOD_W-1:0]  period_calc;
   logic [STEP_BITS-1:0] unit_ext;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   // count / 80 == (count >> 4) / 5
   assign div_x    = 32'(s1_count_ff[STEP_BITS-1:4]);
   assign div_prod = 64'(div_x) * 64'(RECIP_5);
   assign quotient = div_prod[RECIP_SHIFT+UNIT_BITS-1:RECIP_SHIFT];

   assign rem_dec    = remaining_ff - STEP_BITS'(1);
   assign unit_ext   = STEP_BITS'(unit_ff);
   assign threshold  = (stage_ff < STAGE_W'(STAGES)) ? (total_ff - offset_ff) : offset_ff;
   assign next_stage = stage_ff + STAGE_W'(1);

   always_comb begin
      if (s1_kind_ff == KIND_MOVE) begin
         factor_idx = '0;
      end else if (next_stage <= STAGE_W'(STAGES)) begin
         factor_idx = next_stage;
      end else begin
         factor_idx = STAGE_W'(LAST_STAGE) - next_stage;
      end
   end

   assign period_prod = 33'(base_period_ff) * 33'(stage_factor(factor_idx));
   assign period_calc = base_period_ff + period_prod[31:16];

   always_comb begin
      running_in        = running_ff;
      remaining_in      = remaining_ff;
      total_in          = total_ff;
      unit_in           = unit_ff;
      stage_in          = stage_ff;
      offset_in         = offset_ff;
      pwm_enable_in     = 1'b0;
      pwm_disable_in    = 1'b0;
      period_write_in   = 1'b0;
      period_value_in   = '0;
      duty_value_in     = '0;
      move_done_in      = 1'b0;
      start_accepted_in = 1'b0;
      if (s1_kind_ff == KIND_MOVE) begin
         if (s1_count_ff == '0) begin
            running_in     = 1'b0;
            remaining_in   = '0;
            pwm_disable_in = 1'b1;
            move_done_in   = 1'b1;
         end else if (!running_ff) begin
            running_in        = 1'b1;
            remaining_in      = s1_count_ff;
            total_in          = s1_count_ff;
            unit_in           = quotient;
            stage_in          = '0;
            offset_in         = '0;
            pwm_enable_in     = 1'b1;
            start_accepted_in = 1'b1;
            if (tune_enable_ff) begin
               period_write_in = 1'b1;
               period_value_in = period_calc;
               duty_value_in   = duty_ff;
            end
         end
      end else if (running_ff) begin
         remaining_in = rem_dec;
         if (rem_dec == '0) begin
            running_in     = 1'b0;
            pwm_disable_in = 1'b1;
            move_done_in   = 1'b1;
         end else if (tune_enable_ff && stage_ff < STAGE_W'(LAST_STAGE)
                      && rem_dec < threshold) begin
            stage_in = next_stage;
            // offset tracks k*unit, k rising to STAGES then falling
            if (stage_ff < STAGE_W'(STAGES)) begin
               offset_in = offset_ff + unit_ext;
            end else begin
               offset_in = offset_ff - unit_ext;
            end
            period_write_in = 1'b1;
            period_value_in = period_calc;
            duty_value_in   = duty_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_period_ff <= BASE_PERIOD_RST;
         duty_ff        <= DUTY_RST;
         tune_enable_ff <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_BASE_PERIOD: base_period_ff <= csr_write_data;
            CSR_DUTY:        duty_ff        <= csr_write_data;
            CSR_TUNE_ENABLE: tune_enable_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         s1_kind_ff  <= req_kind;
         s1_count_ff <= req_step_count[STEP_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff   <= 1'b0;
         remaining_ff <= '0;
         total_ff     <= '0;
         unit_ff      <= '0;
         stage_ff     <= '0;
         offset_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            running_ff   <= running_in;
            remaining_ff <= remaining_in;
            total_ff     <= total_in;
            unit_ff      <= unit_in;
            stage_ff     <= stage_in;
            offset_ff    <= offset_in;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pwm_enable_ff     <= pwm_enable_in;
         pwm_disable_ff    <= pwm_disable_in;
         period_write_ff   <= period_write_in;
         period_value_ff   <= period_value_in;
         duty_value_ff     <= duty_value_in;
         move_done_ff      <= move_done_in;
         start_accepted_ff <= start_accepted_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pwm_enable     = pwm_enable_ff;
   assign rsp_pwm_disable    = pwm_disable_ff;
   assign rsp_period_write   = period_write_ff;
   assign rsp_period_value   = period_value_ff;
   assign rsp_duty_value     = duty_value_ff;
   assign rsp_move_done      = move_done_ff;
   assign rsp_start_accepted = start_accepted_ff;
   assign rsp_steps_left     = 32'(remaining_ff);

   a_stage_range: assert property (@(posedge clock) disable iff (reset)
      stage_ff <= STAGE_W'(LAST_STAGE))
      else $error("profile stage beyond last stage");

   a_run_count: assert property (@(posedge clock) disable iff (reset)
      running_ff == (remaining_ff != '0))
      else $error("running flag disagrees with remaining count");

   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_move_done |-> rsp_steps_left == 32'd0)
      else $error("done reported with pulses left");

   a_write_not_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_period_write |-> !rsp_pwm_disable && !rsp_move_done)
      else $error("period write on a stopping word");

   a_start_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_start_accepted |-> rsp_pwm_enable && rsp_steps_left != 32'd0)
      else $error("start accepted without pwm enable");

endmodule
`default_nettype wire

>>> sim/tb_stepper_pulse_ramp_profile_top.sv
`timescale 1ns / 1ps
module tb_stepper_pulse_ramp_profile_top;
   import sprp_pkg::*;

   typedef struct {
      kind_type    kind;
      logic [31:0] count;
   } motor_word_type;

   typedef struct packed {
      logic                pwm_enable;
      logic                pwm_disable;
      logic                period_write;
      logic [PERIOD_W-1:0] period_value;
      logic [PERIOD_W-1:0] duty_value;
      logic                move_done;
      logic                start_accepted;
      logic [31:0]         steps_left;
   } pwm_cmd_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_kind = KIND_MOVE;
   logic [31:0]          req_step_count = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_pwm_enable;
   logic                 rsp_pwm_disable;
   logic                 rsp_period_write;
   logic [PERIOD_W-1:0]  rsp_period_value;
   logic [PERIOD_W-1:0]  rsp_duty_value;
   logic                 rsp_move_done;
   logic                 rsp_start_accepted;
   logic [31:0]          rsp_steps_left;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_BASE_PERIOD;
   logic [PERIOD_W-1:0]  csr_write_data = '0;

   // predictor copy of registers and move state
   logic [PERIOD_W-1:0]  base_reg = BASE_PERIOD_RST;
   logic [PERIOD_W-1:0]  duty_reg = DUTY_RST;
   logic                 tune_on = 1'b0;
   logic                 ramp_running = 1'b0;
   logic [31:0]          steps_left_q = '0;
   logic [31:0]          steps_total = '0;
   logic [25:0]          step_unit = '0;
   logic [STAGE_W-1:0]   ramp_stage = '0;

   motor_word_type       motor_words[$];
   pwm_cmd_type          pwm_cmds_due[$];
   motor_word_type       next_word;
   pwm_cmd_type          due_cmd;
   int                   queued_words = 0;
   int                   errors = 0;
   int                   burst_left = 0;
   int                   gap_left = 0;
   int                   stall_left = 0;
   int                   idle_cycles = 0;
   bit                   sender_calm = 0;
   bit                   receiver_calm = 0;

   stepper_pulse_ramp_profile_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_step_count     (req_step_count),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pwm_enable     (rsp_pwm_enable),
      .rsp_pwm_disable    (rsp_pwm_disable),
      .rsp_period_write   (rsp_period_write),
      .rsp_period_value   (rsp_period_value),
      .rsp_duty_value     (rsp_duty_value),
      .rsp_move_done      (rsp_move_done),
      .rsp_start_accepted (rsp_start_accepted),
      .rsp_steps_left     (rsp_steps_left),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [16:0] sigmoid_q16(input logic [STAGE_W-1:0] k);
      case (k)
         0:       return 17'd65536;
         1:       return 17'd64357;
         2:       return 17'd62428;
         3:       return 17'd57724;
         4:       return 17'd47911;
         5:       return 17'd32768;
         6:       return 17'd17625;
         7:       return 17'd7812;
         8:       return 17'd3108;
         9:       return 17'd1179;
         default: return 17'd0;
      endcase
   endfunction

   function automatic logic [PERIOD_W-1:0] ramp_period(input logic [STAGE_W-1:0] st);
      logic [STAGE_W-1:0] k;
      logic [32:0]        prod;
      k = (st <= STAGES) ? st : STAGE_W'(LAST_STAGE - st);
      prod = base_reg * sigmoid_q16(k);
      return PERIOD_W'(base_reg + prod[32:16]);
   endfunction

   function automatic logic [31:0] stage_limit(input logic [STAGE_W-1:0] st);
      if (st < STAGES)
         return steps_total - 32'(st) * 32'(step_unit);
      if (st == STAGES)
         return 32'(STAGES) * 32'(step_unit);
      if (st <= LAST_STAGE)
         return 32'(LAST_STAGE - st) * 32'(step_unit);
      return '0;
   endfunction

   function automatic pwm_cmd_type step_motor(input kind_type kind, input logic [31:0] count);
      pwm_cmd_type c;
      c = '0;
      if (kind == KIND_MOVE) begin
         if (count == 0) begin
            ramp_running = 1'b0;
            steps_left_q = '0;
            c.pwm_disable = 1'b1;
            c.move_done = 1'b1;
         end else if (!ramp_running) begin
            ramp_running = 1'b1;
            steps_left_q = count;
            steps_total = count;
            step_unit = 26'(count / (8 * STAGES));
            ramp_stage = '0;
            if (tune_on) begin
               c.period_write = 1'b1;
               c.period_value = ramp_period(ramp_stage);
               c.duty_value = duty_reg;
            end
            c.pwm_enable = 1'b1;
            c.start_accepted = 1'b1;
         end
      end else if (ramp_running) begin
         steps_left_q = steps_left_q - 32'd1;
         if (steps_left_q == 0) begin
            ramp_running = 1'b0;
            c.pwm_disable = 1'b1;
            c.move_done = 1'b1;
         end else if (tune_on && ramp_stage < LAST_STAGE) begin
            if (steps_left_q < stage_limit(ramp_stage)) begin
               ramp_stage = ramp_stage + STAGE_W'(1);
               c.period_write = 1'b1;
               c.period_value = ramp_period(ramp_stage);
               c.duty_value = duty_reg;
            end
         end
      end
      c.steps_left = steps_left_q;
      return c;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $display("%0t rsp %s: expected %0h, got %0h", $time, name, want, got);
         errors++;
      end
   endtask

   task automatic push_word(input kind_type kind, input logic [31:0] count);
      motor_word_type w;
      w.kind = kind;
      w.count = count;
      motor_words.push_back(w);
      queued_words++;
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [PERIOD_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      case (idx)
         CSR_BASE_PERIOD: base_reg = value;
         CSR_DUTY:        duty_reg = value;
         CSR_TUNE_ENABLE: tune_on = value[0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic wait_drained();
      do
         @(negedge clock);
      while (motor_words.size() != 0 || req_valid || pwm_cmds_due.size() != 0);
   endtask

   // mostly complete moves with random counts, some cut short by a stop,
   // plus stray words and restarts while running
   task automatic queue_random_moves(input int target);
      int          first;
      int          pulses;
      logic [31:0] count;
      first = queued_words;
      while (queued_words - first < target) begin
         if ($urandom_range(0, 99) < 6) begin
            push_word(kind_type'($urandom_range(0, 1)), $urandom);
         end else begin
            case ($urandom_range(0, 9))
               0, 1:    count = $urandom_range(1, 79);
               2:       count = $urandom;
               default: count = $urandom_range(80, 400);
            endcase
            push_word(KIND_MOVE, count);
            pulses = (count > 400) ? $urandom_range(1, 30) : int'(count);
            if ($urandom_range(0, 5) == 0)
               pulses = $urandom_range(0, pulses);
            for (int i = 0; i < pulses; i++) begin
               if ($urandom_range(0, 99) == 0)
                  push_word(KIND_MOVE, $urandom | 32'd1);
               push_word(KIND_PULSE, $urandom);
            end
            if (pulses < count)
               push_word(KIND_MOVE, 32'd0);
         end
      end
   endtask

   // sender: bursts of words separated by random gaps, no new gaps while sender_calm is set
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            pwm_cmds_due.push_back(step_motor(kind_type'(req_kind), req_step_count));
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (motor_words.size() > 0) begin
               next_word = motor_words.pop_front();
               req_valid <= 1'b1;
               req_kind <= next_word.kind;
               req_step_count <= next_word.count;
               if (burst_left > 0) begin
                  burst_left--;
               end else if (!sender_calm) begin
                  burst_left = $urandom_range(0, 24);
                  gap_left = $urandom_range(1, 10);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: random stalls, none while receiver_calm is set
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (receiver_calm) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 3) == 0)
            stall_left = $urandom_range(1, 12);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pwm_cmds_due.size() == 0) begin
            $display("%0t rsp word with none pending: expected none, got %0h", $time,
                     {rsp_pwm_enable, rsp_pwm_disable, rsp_period_write, rsp_period_value,
                      rsp_duty_value, rsp_move_done, rsp_start_accepted, rsp_steps_left});
            errors++;
         end else begin
            due_cmd = pwm_cmds_due.pop_front();
            check_field("pwm_enable", due_cmd.pwm_enable, rsp_pwm_enable);
            check_field("pwm_disable", due_cmd.pwm_disable, rsp_pwm_disable);
            check_field("period_write", due_cmd.period_write, rsp_period_write);
            check_field("period_value", due_cmd.period_value, rsp_period_value);
            check_field("duty_value", due_cmd.duty_value, rsp_duty_value);
            check_field("move_done", due_cmd.move_done, rsp_move_done);
            check_field("start_accepted", due_cmd.start_accepted, rsp_start_accepted);
            check_field("steps_left", due_cmd.steps_left, rsp_steps_left);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= 3000) begin
         $display("%0t timeout: no word moved for %0d cycles", $time, idle_cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset defaults, ramp off
      @(negedge clock);
      push_word(KIND_PULSE, 32'hFFFF_FFFF);
      push_word(KIND_MOVE, 32'd0);
      push_word(KIND_MOVE, 32'hFFFF_FFFF);
      push_word(KIND_PULSE, 32'd0);
      push_word(KIND_MOVE, 32'd5);
      push_word(KIND_PULSE, 32'h5555_AAAA);
      push_word(KIND_MOVE, 32'd0);
      push_word(KIND_MOVE, 32'd1);
      push_word(KIND_PULSE, 32'hAAAA_5555);
      wait_drained();

      // ramp on at full-scale period and duty
      csr_write(CSR_BASE_PERIOD, 16'hFFFF);
      csr_write(CSR_DUTY, 16'hFFFF);
      csr_write(CSR_TUNE_ENABLE, 16'd1);
      @(negedge clock);
      push_word(KIND_MOVE, 32'd1);
      push_word(KIND_PULSE, 32'd0);
      push_word(KIND_MOVE, 32'd3);
      repeat (3) push_word(KIND_PULSE, 32'd0);
      push_word(KIND_MOVE, 32'd85);
      repeat (3) push_word(KIND_PULSE, $urandom);
      push_word(KIND_MOVE, 32'd7);
      push_word(KIND_MOVE, 32'd0);
      push_word(KIND_MOVE, 32'h8000_0000);
      push_word(KIND_PULSE, 32'd0);
      push_word(KIND_MOVE, 32'd0);
      wait_drained();

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               csr_write(CSR_BASE_PERIOD, PERIOD_W'($urandom));
               csr_write(CSR_DUTY, PERIOD_W'($urandom));
            end
            1: begin
               csr_write(CSR_BASE_PERIOD, 16'd0);
               csr_write(CSR_DUTY, 16'd0);
            end
            2: begin
               csr_write(CSR_BASE_PERIOD, 16'hFFFF);
               csr_write(CSR_DUTY, PERIOD_W'($urandom));
            end
            3: begin
               csr_write(CSR_TUNE_ENABLE, 16'd0);
               csr_write(CSR_BASE_PERIOD, PERIOD_W'($urandom));
            end
            default: begin
               csr_write(CSR_TUNE_ENABLE, 16'd1);
               csr_write(CSR_BASE_PERIOD, PERIOD_W'($urandom_range(1, 3000)));
               csr_write(CSR_DUTY, 16'hFFFF);
            end
         endcase
         @(negedge clock);
         sender_calm = (phase == 1);
         receiver_calm = (phase == 1 || phase == 4);
         queue_random_moves(300);
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (errors == 0 && pwm_cmds_due.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
